// ===== rtl/particle_motion_step_wrap_core_assert.svh =====
// Assertion macros for the checker file.
`ifndef PARTICLE_MOTION_STEP_WRAP_CORE_ASSERT_SVH
`define PARTICLE_MOTION_STEP_WRAP_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define PMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define PMS_ASSERT_NEXT(lbl, trig, cond, msg) \
	`PMS_ASSERT(lbl, (trig) |=> (cond), msg)

`endif

// ===== rtl/pms_pkg.sv =====
package pms_pkg;

	localparam int FRAC_BITS = 8;
	localparam int POS_W     = 14;
	localparam int VEL_W     = 15;
	localparam int MAG_W     = 15;
	localparam int SPD_W     = 6;
	localparam int SPDF_W    = SPD_W + FRAC_BITS;
	localparam int DT_W      = 10;
	localparam int SIZE_W    = 7;
	localparam int RAD_W     = 2 * MAG_W;
	localparam int PA_W      = MAG_W + SPDF_W;
	localparam int NUM_W     = PA_W + DT_W;
	localparam int DEN_W     = 26;
	localparam int QUO_W     = 14;
	localparam int SUMV_W    = VEL_W + 1;
	localparam int PROD_W    = 24;
	localparam int RECIP_W   = 23;
	localparam int RECIP_SH  = 32;
	localparam int DIST_W    = 15;
	localparam int PSUM_W    = POS_W + 3;
	localparam int CELL_W    = POS_W - FRAC_BITS;
	localparam int MODU_W    = 14;

	localparam int GROW_DIV  = 2000;
	localparam int MOVE_DIV  = 1000;
	localparam int SIZE_MAX  = 64;
	// 2^32 does not fit in 32 bits; form the reciprocal in 64-bit math.
	localparam int RECIP_1000 = int'((64'd1 << RECIP_SH) / MOVE_DIV);

	localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(64);
	localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(32);

	typedef enum logic [0:0] {
		REG_FIELD_WIDTH  = 1'b0,
		REG_FIELD_HEIGHT = 1'b1
	} reg_idx_t;

	// Front end: magnitudes and signs of the velocity plus pass-along fields.
	typedef struct packed {
		logic              sx;
		logic              sy;
		logic [VEL_W-1:0]  ax;
		logic [VEL_W-1:0]  ay;
		logic [SPDF_W-1:0] spd;
		logic [DT_W-1:0]   dt;
		logic [POS_W-1:0]  px;
		logic [POS_W-1:0]  py;
		logic              last;
	} front_t;

	typedef struct packed {
		logic             sx;
		logic             sy;
		logic [VEL_W-1:0] ax;
		logic [VEL_W-1:0] ay;
		logic             resc;
		logic             zero;
		logic [DT_W-1:0]  dt;
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		logic             last;
	} dside_t;

	typedef struct packed {
		logic             sx;
		logic             sy;
		logic [VEL_W-1:0] mx;
		logic [VEL_W-1:0] my;
		logic [DT_W-1:0]  dt;
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		logic             last;
	} move_t;

	typedef struct packed {
		logic                 sx;
		logic                 sy;
		logic [VEL_W-1:0]     mx;
		logic [VEL_W-1:0]     my;
		logic [FRAC_BITS-1:0] lox;
		logic [FRAC_BITS-1:0] loy;
		logic                 last;
	} mside_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] r;
		r = s;
		if (s == '0)
			r = SIZE_W'(1);
		else if (s > SIZE_W'(SIZE_MAX))
			r = SIZE_W'(SIZE_MAX);
		return r;
	endfunction

endpackage

// ===== rtl/pms_if.sv =====
interface pms_item_if;
	import pms_pkg::*;
	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  pos_x;
	logic [POS_W-1:0]  pos_y;
	logic signed [VEL_W-1:0] vel_x;
	logic signed [VEL_W-1:0] vel_y;
	logic [SPD_W-1:0]  target_speed;
	logic [DT_W-1:0]   elapsed_ms;
	logic              last_particle;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, target_speed, elapsed_ms,
		last_particle, input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, target_speed, elapsed_ms,
		last_particle, output ready);
endinterface

interface pms_result_if;
	import pms_pkg::*;
	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  new_pos_x;
	logic [POS_W-1:0]  new_pos_y;
	logic signed [VEL_W-1:0] new_vel_x;
	logic signed [VEL_W-1:0] new_vel_y;
	logic              frame_done;

	modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, frame_done,
		input ready);
	modport sink (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, frame_done,
		output ready);
endinterface

// ===== rtl/pms_sqrt_pipe.sv =====
// Floor square root, one root bit per stage; the running square is kept by shift-add.
module pms_sqrt_pipe import pms_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  in_rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [MAG_W-1:0]  out_root,
	output logic [SIDE_W-1:0] out_side
);
	localparam int SQ_W = RAD_W + 1;

	logic              vld_s  [0:MAG_W];
	logic [MAG_W-1:0]  root_s [0:MAG_W];
	logic [SQ_W-1:0]   sq_s   [0:MAG_W];
	logic [RAD_W-1:0]  rad_s  [0:MAG_W];
	logic [SIDE_W-1:0] side_s [0:MAG_W];

	assign vld_s[0]  = in_valid;
	assign root_s[0] = '0;
	assign sq_s[0]   = '0;
	assign rad_s[0]  = in_rad;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < MAG_W; k++) begin : g_stage
		localparam int B = MAG_W - 1 - k;
		logic [SQ_W-1:0] cand;
		logic            take;

		always_comb begin
			cand = sq_s[k] + (SQ_W'(root_s[k]) << (B + 1)) + (SQ_W'(1) << (2 * B));
			take = cand <= SQ_W'(rad_s[k]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k+1] <= take ? (root_s[k] | (MAG_W'(1) << B)) : root_s[k];
				sq_s[k+1]   <= take ? cand : sq_s[k];
				rad_s[k+1]  <= rad_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[MAG_W];
	assign out_root  = root_s[MAG_W];
	assign out_side  = side_s[MAG_W];
endmodule

// ===== rtl/pms_div_pipe.sv =====
// Restoring divider, two numerators over one shared divisor, one quotient bit per stage.
module pms_div_pipe import pms_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num_a,
	input  logic [NUM_W-1:0]  num_b,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quo_a,
	output logic [QUO_W-1:0]  quo_b,
	output logic [SIDE_W-1:0] out_side
);
	localparam int CMP_W = NUM_W + 1;

	logic              vld_s  [0:QUO_W];
	logic [NUM_W-1:0]  ra_s   [0:QUO_W];
	logic [NUM_W-1:0]  rb_s   [0:QUO_W];
	logic [QUO_W-1:0]  qa_s   [0:QUO_W];
	logic [QUO_W-1:0]  qb_s   [0:QUO_W];
	logic [DEN_W-1:0]  den_s  [0:QUO_W];
	logic [SIDE_W-1:0] side_s [0:QUO_W];

	assign vld_s[0]  = in_valid;
	assign ra_s[0]   = num_a;
	assign rb_s[0]   = num_b;
	assign qa_s[0]   = '0;
	assign qb_s[0]   = '0;
	assign den_s[0]  = den;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int B = QUO_W - 1 - k;
		logic [CMP_W-1:0] sh;
		logic             ta;
		logic             tb;

		always_comb begin
			sh = CMP_W'(den_s[k]) << B;
			ta = CMP_W'(ra_s[k]) >= sh;
			tb = CMP_W'(rb_s[k]) >= sh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ra_s[k+1]   <= ta ? NUM_W'(CMP_W'(ra_s[k]) - sh) : ra_s[k];
				rb_s[k+1]   <= tb ? NUM_W'(CMP_W'(rb_s[k]) - sh) : rb_s[k];
				qa_s[k+1]   <= qa_s[k] | (QUO_W'(ta) << B);
				qb_s[k+1]   <= qb_s[k] | (QUO_W'(tb) << B);
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign quo_a     = qa_s[QUO_W];
	assign quo_b     = qb_s[QUO_W];
	assign out_side  = side_s[QUO_W];
endmodule

// ===== rtl/pms_mod_pipe.sv =====
// Remainder by the field size in whole pixels, one conditional subtract per stage.
module pms_mod_pipe import pms_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [MODU_W-1:0] val_a,
	input  logic [MODU_W-1:0] val_b,
	input  logic [SIZE_W-1:0] size_a,
	input  logic [SIZE_W-1:0] size_b,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [CELL_W-1:0] rem_a,
	output logic [CELL_W-1:0] rem_b,
	output logic [SIDE_W-1:0] out_side
);
	localparam int CMP_W = MODU_W + SIZE_W;

	logic              vld_s  [0:MODU_W];
	logic [MODU_W-1:0] ua_s   [0:MODU_W];
	logic [MODU_W-1:0] ub_s   [0:MODU_W];
	logic [SIDE_W-1:0] side_s [0:MODU_W];

	assign vld_s[0]  = in_valid;
	assign ua_s[0]   = val_a;
	assign ub_s[0]   = val_b;
	assign side_s[0] = in_side;

	// The user must keep the sizes still while items are in flight; this block does not enforce it.
	for (genvar k = 0; k < MODU_W; k++) begin : g_stage
		localparam int B = MODU_W - 1 - k;
		logic [CMP_W-1:0] sha;
		logic [CMP_W-1:0] shb;
		logic             ta;
		logic             tb;

		always_comb begin
			sha = CMP_W'(size_a) << B;
			shb = CMP_W'(size_b) << B;
			ta  = CMP_W'(ua_s[k]) >= sha;
			tb  = CMP_W'(ub_s[k]) >= shb;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ua_s[k+1]   <= ta ? MODU_W'(CMP_W'(ua_s[k]) - sha) : ua_s[k];
				ub_s[k+1]   <= tb ? MODU_W'(CMP_W'(ub_s[k]) - shb) : ub_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[MODU_W];
	assign rem_a     = ua_s[MODU_W][CELL_W-1:0];
	assign rem_b     = ub_s[MODU_W][CELL_W-1:0];
	assign out_side  = side_s[MODU_W];
endmodule

// ===== rtl/particle_motion_step_wrap_core.sv =====
// Particle motion step with toroidal wrap. One particle beat in gives one result beat
// out; a new particle is taken every cycle while the output side keeps up. The whole
// pipeline advances on one enable, which is low only while a finished result waits
// at the output register, so a stall freezes every stage and nothing is lost or
// repeated. Three bit-per-stage units form its core: a 15-stage square root
// for the velocity length, a 14-stage divider for rescale or growth, and a 14-stage
// remainder unit for the wrap; the rest is nine single-stage steps (abs, squares,
// products, reciprocal divide by 1000, position add) plus the output register.
// Velocities are signed Q7.8 and saturate at the 15-bit range; positions are unsigned
// Q6.8. A zero velocity stays zero. field_width and field_height clamp to 1..64 and
// must only be written while no particle is in flight.
module particle_motion_step_wrap_core import pms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [0:0]        wr_idx,
	input  logic [SIZE_W-1:0] wr_data,
	pms_item_if.sink          item,
	pms_result_if.source      result
);
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic              en;
	logic              out_v_q;

	// Advance everything unless the output holds an untaken beat.
	assign en         = !out_v_q || result.ready;
	assign item.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_idx))
				REG_FIELD_WIDTH:  width_q  <= wr_data;
				REG_FIELD_HEIGHT: height_q <= wr_data;
			endcase
		end
	end

	// Stage 1: split velocity into sign and magnitude, scale speed.
	front_t f_s1;
	logic   v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= item.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1.sx   <= item.vel_x[VEL_W-1];
			f_s1.sy   <= item.vel_y[VEL_W-1];
			f_s1.ax   <= item.vel_x[VEL_W-1] ? VEL_W'(-item.vel_x) : VEL_W'(item.vel_x);
			f_s1.ay   <= item.vel_y[VEL_W-1] ? VEL_W'(-item.vel_y) : VEL_W'(item.vel_y);
			f_s1.spd  <= {item.target_speed, FRAC_BITS'(0)};
			f_s1.dt   <= item.elapsed_ms;
			f_s1.px   <= item.pos_x;
			f_s1.py   <= item.pos_y;
			f_s1.last <= item.last_particle;
		end
	end

	// Stage 2: squared length.
	front_t           f_s2;
	logic             v_s2;
	logic [RAD_W-1:0] rad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s2   <= f_s1;
			rad_s2 <= (RAD_W'(f_s1.ax) * RAD_W'(f_s1.ax)) + (RAD_W'(f_s1.ay) * RAD_W'(f_s1.ay));
		end
	end

	// Velocity length.
	logic             v_sq;
	logic [MAG_W-1:0] mag_sq;
	front_t           f_sq;

	pms_sqrt_pipe #(.SIDE_W($bits(front_t))) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_rad    (rad_s2),
		.in_side   (f_s2),
		.out_valid (v_sq),
		.out_root  (mag_sq),
		.out_side  (f_sq)
	);

	// Stage 3: pick rescale or growth, form v*S and the divisor.
	dside_t           ds_s3;
	logic             v_s3;
	logic [PA_W-1:0]  pa_s3;
	logic [PA_W-1:0]  pb_s3;
	logic [DEN_W-1:0] den_s3;
	logic             resc;

	assign resc = MAG_W'(f_sq.spd) < mag_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_sq;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ds_s3.sx   <= f_sq.sx;
			ds_s3.sy   <= f_sq.sy;
			ds_s3.ax   <= f_sq.ax;
			ds_s3.ay   <= f_sq.ay;
			ds_s3.resc <= resc;
			ds_s3.zero <= mag_sq == '0;
			ds_s3.dt   <= f_sq.dt;
			ds_s3.px   <= f_sq.px;
			ds_s3.py   <= f_sq.py;
			ds_s3.last <= f_sq.last;
			pa_s3      <= PA_W'(f_sq.ax) * PA_W'(f_sq.spd);
			pb_s3      <= PA_W'(f_sq.ay) * PA_W'(f_sq.spd);
			den_s3     <= resc ? DEN_W'(mag_sq) : DEN_W'(mag_sq) * DEN_W'(GROW_DIV);
		end
	end

	// Stage 4: growth scales the numerator by the time step.
	dside_t           ds_s4;
	logic             v_s4;
	logic [NUM_W-1:0] na_s4;
	logic [NUM_W-1:0] nb_s4;
	logic [DEN_W-1:0] den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ds_s4  <= ds_s3;
			na_s4  <= ds_s3.resc ? NUM_W'(pa_s3) : NUM_W'(pa_s3) * NUM_W'(ds_s3.dt);
			nb_s4  <= ds_s3.resc ? NUM_W'(pb_s3) : NUM_W'(pb_s3) * NUM_W'(ds_s3.dt);
			den_s4 <= den_s3;
		end
	end

	logic             v_dv;
	logic [QUO_W-1:0] qa_dv;
	logic [QUO_W-1:0] qb_dv;
	dside_t           ds_dv;

	pms_div_pipe #(.SIDE_W($bits(dside_t))) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num_a     (na_s4),
		.num_b     (nb_s4),
		.den       (den_s4),
		.in_side   (ds_s4),
		.out_valid (v_dv),
		.quo_a     (qa_dv),
		.quo_b     (qb_dv),
		.out_side  (ds_dv)
	);

	// Stage 5: new velocity magnitude, saturated per sign.
	logic [SUMV_W-1:0] sum_x;
	logic [SUMV_W-1:0] sum_y;
	logic [SUMV_W-1:0] lim_x;
	logic [SUMV_W-1:0] lim_y;
	move_t             mv_s5;
	logic              v_s5;

	always_comb begin
		if (ds_dv.zero) begin
			sum_x = '0;
			sum_y = '0;
		end else if (ds_dv.resc) begin
			sum_x = SUMV_W'(qa_dv);
			sum_y = SUMV_W'(qb_dv);
		end else begin
			sum_x = SUMV_W'(ds_dv.ax) + SUMV_W'(qa_dv);
			sum_y = SUMV_W'(ds_dv.ay) + SUMV_W'(qb_dv);
		end
		lim_x = ds_dv.sx ? SUMV_W'(2 ** (VEL_W - 1)) : SUMV_W'(2 ** (VEL_W - 1) - 1);
		lim_y = ds_dv.sy ? SUMV_W'(2 ** (VEL_W - 1)) : SUMV_W'(2 ** (VEL_W - 1) - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_dv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mv_s5.sx   <= ds_dv.sx;
			mv_s5.sy   <= ds_dv.sy;
			mv_s5.mx   <= VEL_W'((sum_x > lim_x) ? lim_x : sum_x);
			mv_s5.my   <= VEL_W'((sum_y > lim_y) ? lim_y : sum_y);
			mv_s5.dt   <= ds_dv.dt;
			mv_s5.px   <= ds_dv.px;
			mv_s5.py   <= ds_dv.py;
			mv_s5.last <= ds_dv.last;
		end
	end

	// Stage 6: |v'| * dt.
	move_t             mv_s6;
	logic              v_s6;
	logic [PROD_W-1:0] prx_s6;
	logic [PROD_W-1:0] pry_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mv_s6  <= mv_s5;
			prx_s6 <= PROD_W'(mv_s5.mx) * PROD_W'(mv_s5.dt);
			pry_s6 <= PROD_W'(mv_s5.my) * PROD_W'(mv_s5.dt);
		end
	end

	// Stage 7: estimate of the quotient by 1000, low by at most one.
	localparam int RP_W = PROD_W + RECIP_W;

	move_t             mv_s7;
	logic              v_s7;
	logic [PROD_W-1:0] prx_s7;
	logic [PROD_W-1:0] pry_s7;
	logic [DIST_W-1:0] qx_s7;
	logic [DIST_W-1:0] qy_s7;
	logic [RP_W-1:0]   rpx;
	logic [RP_W-1:0]   rpy;

	always_comb begin
		rpx = RP_W'(prx_s6) * RP_W'(RECIP_1000);
		rpy = RP_W'(pry_s6) * RP_W'(RECIP_1000);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (en)
			v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mv_s7  <= mv_s6;
			prx_s7 <= prx_s6;
			pry_s7 <= pry_s6;
			qx_s7  <= rpx[RECIP_SH +: DIST_W];
			qy_s7  <= rpy[RECIP_SH +: DIST_W];
		end
	end

	// Stage 8: correct the estimate by one compare.
	localparam int RM_W = PROD_W + 1;

	move_t             mv_s8;
	logic              v_s8;
	logic [DIST_W-1:0] dx_s8;
	logic [DIST_W-1:0] dy_s8;
	logic [RM_W-1:0]   rmx;
	logic [RM_W-1:0]   rmy;

	always_comb begin
		rmx = RM_W'(prx_s7) - RM_W'(qx_s7) * RM_W'(MOVE_DIV);
		rmy = RM_W'(pry_s7) - RM_W'(qy_s7) * RM_W'(MOVE_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (en)
			v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mv_s8 <= mv_s7;
			dx_s8 <= qx_s7 + DIST_W'(rmx >= RM_W'(MOVE_DIV));
			dy_s8 <= qy_s7 + DIST_W'(rmy >= RM_W'(MOVE_DIV));
		end
	end

	// Stage 9: move, split into whole pixels and fraction, bias pixels non-negative.
	logic [SIZE_W-1:0] szx;
	logic [SIZE_W-1:0] szy;
	logic [PSUM_W-1:0] pnx;
	logic [PSUM_W-1:0] pny;
	localparam int HI_W = PSUM_W - FRAC_BITS;

	assign szx = clamp_size(width_q);
	assign szy = clamp_size(height_q);

	always_comb begin
		pnx = PSUM_W'(mv_s8.px) + (mv_s8.sx ? PSUM_W'(0) - PSUM_W'(dx_s8) : PSUM_W'(dx_s8));
		pny = PSUM_W'(mv_s8.py) + (mv_s8.sy ? PSUM_W'(0) - PSUM_W'(dy_s8) : PSUM_W'(dy_s8));
	end

	mside_t            ms_s9;
	logic              v_s9;
	logic [MODU_W-1:0] ux_s9;
	logic [MODU_W-1:0] uy_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s9 <= 1'b0;
		else if (en)
			v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ms_s9.sx   <= mv_s8.sx;
			ms_s9.sy   <= mv_s8.sy;
			ms_s9.mx   <= mv_s8.mx;
			ms_s9.my   <= mv_s8.my;
			ms_s9.lox  <= pnx[FRAC_BITS-1:0];
			ms_s9.loy  <= pny[FRAC_BITS-1:0];
			ms_s9.last <= mv_s8.last;
			ux_s9 <= {{(MODU_W - HI_W){pnx[PSUM_W-1]}}, pnx[PSUM_W-1:FRAC_BITS]}
				+ {szx, (MODU_W - SIZE_W)'(0)};
			uy_s9 <= {{(MODU_W - HI_W){pny[PSUM_W-1]}}, pny[PSUM_W-1:FRAC_BITS]}
				+ {szy, (MODU_W - SIZE_W)'(0)};
		end
	end

	// Wrap whole pixels into the field.
	logic              v_md;
	logic [CELL_W-1:0] rx_md;
	logic [CELL_W-1:0] ry_md;
	mside_t            ms_md;

	pms_mod_pipe #(.SIDE_W($bits(mside_t))) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s9),
		.val_a     (ux_s9),
		.val_b     (uy_s9),
		.size_a    (szx),
		.size_b    (szy),
		.in_side   (ms_s9),
		.out_valid (v_md),
		.rem_a     (rx_md),
		.rem_b     (ry_md),
		.out_side  (ms_md)
	);

	// Output register: hold the beat until taken.
	logic [POS_W-1:0] opx_q;
	logic [POS_W-1:0] opy_q;
	logic [VEL_W-1:0] ovx_q;
	logic [VEL_W-1:0] ovy_q;
	logic             olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (en)
			out_v_q <= v_md;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			opx_q   <= {rx_md, ms_md.lox};
			opy_q   <= {ry_md, ms_md.loy};
			ovx_q   <= ms_md.sx ? VEL_W'(0) - ms_md.mx : ms_md.mx;
			ovy_q   <= ms_md.sy ? VEL_W'(0) - ms_md.my : ms_md.my;
			olast_q <= ms_md.last;
		end
	end

	assign result.valid      = out_v_q;
	assign result.new_pos_x  = opx_q;
	assign result.new_pos_y  = opy_q;
	assign result.new_vel_x  = ovx_q;
	assign result.new_vel_y  = ovy_q;
	assign result.frame_done = olast_q;
endmodule

// ===== rtl/pms_checker.sv =====
`include "particle_motion_step_wrap_core_assert.svh"

module pms_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic result_valid,
	input logic result_ready
);
	// Input side stalls exactly when a result waits untaken.
	`PMS_ASSERT(a_ready_rule, item_ready == (!result_valid || result_ready), "ready mismatch")
	// Reset leaves no result pending.
	`PMS_ASSERT(a_reset_empty, !$past(arst_n) |-> !result_valid, "result after reset")
	// A waiting result stays offered.
	`PMS_ASSERT_NEXT(a_valid_hold, result_valid && !result_ready, result_valid, "result dropped")
	// Input valid is always driven to a known level.
	`PMS_ASSERT(a_item_known, !$isunknown(item_valid), "item valid unknown")
endmodule

bind particle_motion_step_wrap_core pms_checker u_pms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready)
);
